// File: rtl/bvc_pkg.sv
`default_nettype none
package bvc_pkg;
  localparam int NUM_CLASSES = 8;
  localparam int NUM_RAMS    = 256;
  localparam int VOTE_BITS   = 16;
  localparam int CLS_W  = $clog2(NUM_CLASSES);
  localparam int RAM_W  = $clog2(NUM_RAMS);
  localparam int ADDR_W = CLS_W + RAM_W;
  localparam int DEPTH  = NUM_CLASSES * NUM_RAMS;
  localparam int SCORE_W = 9;
  localparam int THR_W   = VOTE_BITS + 1;
  localparam int QDEPTH  = 2;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  localparam logic [1:0] CFG_BLEACH = 2'd0;
  localparam logic [1:0] CFG_CLASSES = 2'd1;
  localparam logic [1:0] CFG_RAMS = 2'd2;

  // result request handed from the classifier to the output queue
  typedef struct packed {
    logic [2:0]         cls;
    logic [SCORE_W-1:0] score;
    logic               winner;
    logic               last;
  } res_t;
endpackage
`default_nettype wire

// File: rtl/bvc_ram.sv
`default_nettype none
module bvc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/bvc_queue.sv
`default_nettype none
module bvc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire bvc_pkg::res_t din,
  output logic               full,
  output logic               valid,
  input  wire logic          pop,
  output bvc_pkg::res_t      dout
);
  import bvc_pkg::*;
  res_t q_r [QDEPTH];
  logic [1:0] cnt_r;
  assign full  = (cnt_r == 2'(QDEPTH));
  assign valid = (cnt_r != 2'd0);
  assign dout  = q_r[0];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (pop) begin
      q_r[0] <= (push && cnt_r == 2'd1) ? din : q_r[1];
      if (push && cnt_r == 2'd2) q_r[1] <= din;
    end else if (push) begin
      if (cnt_r == 2'd0) q_r[0] <= din;
      else q_r[1] <= din;
    end
  end
endmodule
`default_nettype wire

// File: rtl/bvc_front.sv
`default_nettype none
module bvc_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [2:0]                    in_class_index,
  input  wire logic [7:0]                    in_ram_index,
  input  wire logic [15:0]                   in_vote_count,
  input  wire logic                          in_last_vote,
  input  wire logic                          bleach_en,
  input  wire logic [bvc_pkg::CLS_W:0]       ncls,
  input  wire logic [bvc_pkg::RAM_W:0]       nram,
  output logic                               q_push,
  output bvc_pkg::res_t                      q_din,
  input  wire logic                          q_full
);
  import bvc_pkg::*;
  localparam logic [2:0] S_LOAD = 3'd0, S_CNT = 3'd1, S_EVAL = 3'd2,
                         S_EMIT = 3'd3, S_FIN = 3'd4;
  logic [2:0] st_r, st_nxt;
  logic [CLS_W-1:0] c_r;
  logic [RAM_W:0]   r_r;
  logic             rv_r;
  logic [SCORE_W-1:0] acc_r;
  logic [SCORE_W-1:0] sc_r [NUM_CLASSES];
  logic [THR_W-1:0] thr_r, nlev_r;
  logic             final_r;
  logic [SCORE_W-1:0] top_r;
  logic             tied_r;
  logic [CLS_W-1:0] win_r;
  logic [VOTE_BITS-1:0] rdata;
  logic [ADDR_W-1:0] raddr;
  logic              we;

  assign in_ready = (st_r == S_LOAD);
  assign we = in_valid && in_ready &&
              (32'(in_class_index) < NUM_CLASSES) && (32'(in_ram_index) < NUM_RAMS);
  assign raddr = {c_r, r_r[RAM_W-1:0]};

  bvc_ram #(.WIDTH(VOTE_BITS), .DEPTH(DEPTH)) u_votes (
    .clk(clk), .we(we),
    .waddr({in_class_index[CLS_W-1:0], in_ram_index[RAM_W-1:0]}),
    .wdata(in_vote_count[VOTE_BITS-1:0]), .raddr(raddr), .rdata(rdata)
  );

  logic [THR_W-1:0] v;
  logic scan_end, last_cls;
  logic [SCORE_W-1:0] top_e;
  logic tied_e, go_on;
  assign v = THR_W'(rdata);
  assign last_cls = ({1'b0, c_r} + 1'b1 == ncls);
  assign scan_end = ({1'b0, r_r} >= {1'b0, nram});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD;
      rv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rv_r <= (st_r == S_CNT) && !scan_end;
    end
    unique case (st_r)
      S_LOAD: if (in_valid && in_last_vote) begin
        c_r <= '0; r_r <= '0; acc_r <= '0; thr_r <= THR_W'(1);
        nlev_r <= '0; final_r <= !bleach_en;
      end
      S_CNT: begin
        if (rv_r) begin
          if (v >= thr_r && acc_r != SCORE_MAX) acc_r <= acc_r + 1'b1;
          if (v > thr_r && (nlev_r == '0 || v < nlev_r)) nlev_r <= v;
        end
        if (!scan_end) r_r <= r_r + 1'b1;
        else if (!rv_r) begin
          // pipeline drained: store class score
          sc_r[c_r] <= acc_r;
          acc_r <= '0;
          r_r <= '0;
          if (!last_cls) c_r <= c_r + 1'b1;
          else begin
            c_r <= '0; top_r <= '0; tied_r <= 1'b0;
          end
        end
      end
      S_EVAL: begin
        if (!last_cls) begin
          if (sc_r[c_r] > top_r) begin top_r <= sc_r[c_r]; tied_r <= 1'b0; end
          else if (sc_r[c_r] == top_r) tied_r <= 1'b1;
          c_r <= c_r + 1'b1;
        end else begin
          // decision uses updated top/tied
          c_r <= '0;
          if (go_on) begin
            if (nlev_r == '0) begin thr_r <= thr_r + 1'b1; final_r <= 1'b1; end
            else thr_r <= nlev_r;
            nlev_r <= '0;
          end else top_r <= '0;
        end
      end
      S_FIN: begin
        // winner scan, then emit
        if (sc_r[c_r] >= top_r) begin top_r <= sc_r[c_r]; win_r <= c_r; end
        if (!last_cls) c_r <= c_r + 1'b1;
        else c_r <= '0;
      end
      S_EMIT: if (!q_full) c_r <= c_r + 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    top_e = top_r; tied_e = tied_r;
    if (sc_r[c_r] > top_r) begin top_e = sc_r[c_r]; tied_e = 1'b0; end
    else if (sc_r[c_r] == top_r) tied_e = 1'b1;
    go_on = tied_e && (top_e > SCORE_W'(1));
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_LOAD: if (in_valid && in_last_vote) st_nxt = S_CNT;
      S_CNT: if (scan_end && !rv_r && last_cls) st_nxt = final_r ? S_FIN : S_EVAL;
      S_EVAL: if (last_cls) st_nxt = go_on ? S_CNT : S_FIN;
      S_FIN: if (last_cls) st_nxt = S_EMIT;
      S_EMIT: if (!q_full && last_cls) st_nxt = S_LOAD;
      default: st_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    q_push = (st_r == S_EMIT) && !q_full;
    q_din.cls = 3'(c_r);
    q_din.score = sc_r[c_r];
    q_din.winner = (c_r == win_r);
    q_din.last = last_cls;
  end
endmodule
`default_nettype wire

// File: rtl/bleaching_vote_classifier_core.sv
`default_nettype none
// channel | dir | handshake            | payload
// in      | in  | in_valid/in_ready    | class_index, ram_index, vote_count, last_vote
// out     | out | out_valid/out_ready  | class, score, is_winner, last_score
// cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
// Votes load at one request per cycle, while no scoring is under way, into a vote RAM
// (registered read). A last vote starts scoring: each pass reads every live entry
// from the RAM port, then evaluates the class scores; with bleaching on, passes
// repeat on a tied top score above one. Then a winner scan and emission into a 2-deep queue.
// Synchronous active-low reset; vote RAM holds no reset and no clear pass.
// The output stalls only the queue; the front stalls on a full queue.
module bleaching_vote_classifier_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_class_index,
  input  wire logic [7:0]  in_ram_index,
  input  wire logic [15:0] in_vote_count,
  input  wire logic        in_last_vote,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_class,
  output logic [8:0]       out_score,
  output logic             out_is_winner,
  output logic             out_last_score,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import bvc_pkg::*;
  logic bleach_r;
  logic [3:0] cls_r;
  logic [8:0] rams_r;
  logic [CLS_W:0] ncls;
  logic [RAM_W:0] nram;
  logic q_push, q_full;
  res_t q_din, q_dout;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bleach_r <= 1'b1; cls_r <= 4'd8; rams_r <= 9'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BLEACH:  bleach_r <= cfg_data[0];
        CFG_CLASSES: cls_r <= cfg_data[3:0];
        CFG_RAMS:    rams_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // saturate register values to the built sizes
  always_comb begin
    if (cls_r == 4'd0) ncls = (CLS_W+1)'(1);
    else if (32'(cls_r) > NUM_CLASSES) ncls = (CLS_W+1)'(NUM_CLASSES);
    else ncls = (CLS_W+1)'(cls_r);
    if (32'(rams_r) > NUM_RAMS) nram = (RAM_W+1)'(NUM_RAMS);
    else nram = (RAM_W+1)'(rams_r);
  end

  bvc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_class_index(in_class_index), .in_ram_index(in_ram_index),
    .in_vote_count(in_vote_count), .in_last_vote(in_last_vote),
    .bleach_en(bleach_r), .ncls(ncls), .nram(nram),
    .q_push(q_push), .q_din(q_din), .q_full(q_full)
  );

  bvc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .din(q_din), .full(q_full),
    .valid(out_valid), .pop(out_valid && out_ready), .dout(q_dout)
  );

  assign out_class = q_dout.cls;
  assign out_score = q_dout.score;
  assign out_is_winner = q_dout.winner;
  assign out_last_score = q_dout.last;
endmodule
`default_nettype wire

// File: tb/bvc_score_checker.sv
module bvc_score_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [2:0]  in_class_index,
  input  wire logic [7:0]  in_ram_index,
  input  wire logic [15:0] in_vote_count,
  input  wire logic        in_last_vote,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  out_class,
  input  wire logic [8:0]  out_score,
  input  wire logic        out_is_winner,
  input  wire logic        out_last_score,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               scores_owed
);
  import bvc_pkg::*;

  logic [15:0] votes [NUM_CLASSES][NUM_RAMS];
  logic        bleach_on;
  logic [3:0]  cls_reg;
  logic [8:0]  ram_reg;
  res_t        score_q[$];

  assign scores_owed = score_q.size();

  // tally of RAMs per class at or above the threshold
  task automatic tally(input int nc, input int nr, input logic [THR_W-1:0] thr,
                       ref int sc[NUM_CLASSES]);
    for (int c = 0; c < NUM_CLASSES; c++) begin
      sc[c] = 0;
      if (c < nc)
        for (int r = 0; r < nr; r++)
          if ({1'b0, votes[c][r]} >= thr && sc[c] < SCORE_MAX) sc[c]++;
    end
  endtask

  task automatic classify_pattern();
    int nc, nr, top, best, winner;
    int sc[NUM_CLASSES];
    bit tied, found;
    logic [THR_W-1:0] thr, lvl;
    res_t r;
    nc = (cls_reg < 1) ? 1 : (cls_reg > NUM_CLASSES) ? NUM_CLASSES : cls_reg;
    nr = (ram_reg > NUM_RAMS) ? NUM_RAMS : ram_reg;
    thr = THR_W'(1);
    forever begin
      tally(nc, nr, thr, sc);
      if (!bleach_on) break;
      top = 0;
      tied = 0;
      for (int c = 0; c < nc; c++) begin
        if (sc[c] > top) begin
          top = sc[c];
          tied = 0;
        end else if (sc[c] == top) begin
          tied = 1;
        end
      end
      if (!(tied && top > 1)) break;
      // jump to the next stored vote level; same scores as stepping by one
      found = 0;
      lvl = '0;
      for (int c = 0; c < nc; c++)
        for (int i = 0; i < nr; i++)
          if ({1'b0, votes[c][i]} >= thr + 1 &&
              (!found || {1'b0, votes[c][i]} < lvl)) begin
            lvl = {1'b0, votes[c][i]};
            found = 1;
          end
      if (!found || lvl == 0) begin
        thr = thr + 1'b1;
        tally(nc, nr, thr, sc);
        break;
      end
      thr = lvl;
    end
    best = 0;
    winner = 0;
    for (int c = 0; c < nc; c++)
      if (sc[c] >= best) begin
        best = sc[c];
        winner = c;
      end
    for (int c = 0; c < nc; c++) begin
      r.cls = c[2:0];
      r.score = sc[c][SCORE_W-1:0];
      r.winner = (c == winner);
      r.last = (c + 1 == nc);
      score_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      bleach_on = 1'b1;
      cls_reg = 4'd8;
      ram_reg = 9'd256;
      score_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLEACH:  bleach_on = cfg_data[0];
          CFG_CLASSES: cls_reg = cfg_data[3:0];
          CFG_RAMS:    ram_reg = cfg_data[8:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        votes[in_class_index][in_ram_index] = in_vote_count;
        if (in_last_vote) classify_pattern();
      end
      if (out_valid && out_ready) begin
        if (score_q.size() == 0) begin
          $display("%0t: unexpected score: class %0d score %0d win %b last %b", $time,
                   out_class, out_score, out_is_winner, out_last_score);
          fail_count <= fail_count + 1;
        end else begin
          e = score_q.pop_front();
          if (e.cls !== out_class || e.score !== out_score ||
              e.winner !== out_is_winner || e.last !== out_last_score) begin
            $display({"%0t: score mismatch: exp class %0d score %0d win %b last %b,",
                      " got class %0d score %0d win %b last %b"},
                     $time, e.cls, e.score, e.winner, e.last,
                     out_class, out_score, out_is_winner, out_last_score);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/tb_top.sv
module tb_top;
  import bvc_pkg::*;

  localparam int STALL_LIMIT = 60000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_class_index = '0;
  logic [7:0]  in_ram_index = '0;
  logic [15:0] in_vote_count = '0;
  logic        in_last_vote = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_class;
  logic [8:0]  out_score;
  logic        out_is_winner;
  logic        out_last_score;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int fail_count, scores_owed;
  int idle_pct = 0, stall_pct = 0;
  int votes_sent = 0;
  int quiet_cycles = 0;
  int ncls_live = 8, nram_live = 256;   // effective sizes of the current setting
  bit filled [NUM_CLASSES][NUM_RAMS];   // entries written since reset

  bleaching_vote_classifier_core dut (.*);

  bvc_score_checker chk (.*);

  always #10 clk = ~clk;

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // watchdog: no request moving on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // index 3 names no register; writes there must be ignored
  function automatic logic [1:0] CFG_INDEX_UNUSED_GUARD();
    return 2'd3;
  endfunction

  // idling phases: none, sender idle, receiver stalling, both
  task automatic pick_idling(input int k);
    case (k % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 63; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 63; end
      default: begin idle_pct = 18; stall_pct = 18; end
    endcase
  endtask

  // one vote request; valid held from the previous request when no gap is drawn
  task automatic send_vote(input int c, input int r, input logic [15:0] v, input bit lst);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_class_index <= c[2:0];
    in_ram_index <= r[7:0];
    in_vote_count <= v;
    in_last_vote <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    filled[c][r] = 1'b1;
    votes_sent++;
  endtask

  // block drained: all scores out, then a few cycles for any stored vote in flight
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (scores_owed != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] d);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CLASSES: ncls_live = (d[3:0] < 1) ? 1 : (d[3:0] > 8) ? 8 : d[3:0];
      CFG_RAMS:    nram_live = (d[8:0] > 256) ? 256 : d[8:0];
      default: ;
    endcase
  endtask

  // vote flavours: full range, tiny (deep bleaching), extremes, modest
  function automatic logic [15:0] draw_vote(input int mode);
    logic [15:0] v;
    case (mode)
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(3));
      2: case ($urandom_range(3))
           0: v = 16'd0;
           1: v = 16'd1;
           2: v = 16'hFFFE;
           default: v = 16'hFFFF;
         endcase
      default: v = 16'($urandom_range(20));
    endcase
    return v;
  endfunction

  // full pattern over every live entry, the final one marked last; with no live RAMs, one random vote marked last
  task automatic full_pattern(input int mode);
    int total;
    total = (nram_live == 0) ? 1 : ncls_live * nram_live;
    if (nram_live == 0)
      send_vote($urandom_range(7), $urandom_range(255), draw_vote(mode), 1'b1);
    else
      for (int i = 0; i < total; i++)
        send_vote(i / nram_live, i % nram_live, draw_vote(mode), i == total - 1);
  endtask

  // rewrite a few live entries, last on the final one; only once all are filled, else a full pattern
  task automatic partial_pattern(input int mode, input int k);
    bit ok;
    ok = 1'b1;
    for (int c = 0; c < ncls_live; c++)
      for (int r = 0; r < nram_live; r++)
        if (!filled[c][r]) ok = 1'b0;
    if (!ok || nram_live == 0) begin
      full_pattern(mode);
    end else begin
      for (int i = 0; i < k; i++)
        send_vote($urandom_range(ncls_live - 1), $urandom_range(nram_live - 1),
                  draw_vote(mode), i == k - 1);
    end
  endtask

  initial begin
    int pat;
    logic [15:0] d;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes of votes and registers, ties, bleaching off
    pick_idling(0);
    cfg_write(CFG_BLEACH, 16'h0001);
    cfg_write(CFG_CLASSES, 16'd2);
    cfg_write(CFG_RAMS, 16'd2);
    full_pattern(2);
    cfg_write(CFG_CLASSES, 16'd3);
    cfg_write(CFG_RAMS, 16'd4);
    full_pattern(1);
    cfg_write(CFG_BLEACH, 16'hFFFE);      // bleaching off, upper bits ignored
    partial_pattern(1, 3);
    cfg_write(CFG_CLASSES, 16'd0);         // saturates to one class
    cfg_write(CFG_RAMS, 16'd0);            // no RAMs: all scores zero
    full_pattern(0);
    cfg_write(CFG_BLEACH, 16'h0001);
    cfg_write(CFG_CLASSES, 16'hFFFF);      // saturates to all classes
    cfg_write(CFG_RAMS, 16'd3);
    full_pattern(1);
    cfg_write(CFG_INDEX_UNUSED_GUARD(), 16'h5A5A);
    // one class over every RAM, then oversized RAM counts
    cfg_write(CFG_CLASSES, 16'd1);
    cfg_write(CFG_RAMS, 16'd256);
    pick_idling(3);
    full_pattern(0);
    cfg_write(CFG_RAMS, 16'd300);
    partial_pattern(0, 2);
    cfg_write(CFG_RAMS, 16'h01FF);
    cfg_write(CFG_BLEACH, 16'h0000);
    partial_pattern(2, 2);

    // random: mostly well-formed patterns on small sizes, some noise votes
    pat = 0;
    while (votes_sent < 370) begin
      pick_idling(pat / 3);
      if (pat % 3 == 0) begin
        d = $urandom;
        cfg_write(CFG_BLEACH, {d[15:1], 1'($urandom_range(1))});
        d = $urandom;
        cfg_write(CFG_CLASSES, {d[15:4], 4'($urandom_range(15))});
        d = $urandom;
        cfg_write(CFG_RAMS, {d[15:9], 9'(($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6))});
      end
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 4))
          send_vote($urandom_range(7), $urandom_range(255), draw_vote($urandom_range(3)), 1'b0);
      if ($urandom_range(2) == 0) partial_pattern($urandom_range(3), $urandom_range(1, 5));
      else full_pattern($urandom_range(3));
      pat++;
    end

    drain();
    repeat (50) @(negedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
